/* hw/rtl/drr_pkg.sv */
// package: shared types and constants for the decimal digit reverser
`timescale 1ns / 1ps
package drr_pkg;

  // field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned RevW   = 35;
  localparam int unsigned CntW   = 4;

  // default digit capacity of the converter
  localparam int unsigned DefaultMaxDigits = 10;

  // reciprocal of ten: floor(x / 10) == (x * Recip10) >> Recip10Shift for every 32-bit x
  localparam logic [ValueW-1:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned       Recip10Shift = 35;

  // word travelling down the digit pipeline
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [RevW-1:0]   rev;
    logic [CntW-1:0]   cnt;
  } drr_item_t;

endpackage

/* hw/rtl/decimal_digit_reverse.sv */
// module: top level of the pipelined decimal digit reverser
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | value_i (32 bit signed)
//   out     | output    | out_valid_o / out_ready_i | reversed_o (35 bit signed), digit_count_o
//
// one word enters per cycle while the output is not stalled; each word passes through
// the stages in order (sign split, one stage per decimal digit, sign restore)
// reset clears only the stage valid bits, so the pipeline comes up empty
// a stall at the output backs up stage by stage; an empty stage keeps taking words
`timescale 1ns / 1ps
module decimal_digit_reverse
  import drr_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = DefaultMaxDigits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [RevW-1:0] reversed_o,
  output logic        [CntW-1:0] digit_count_o
);

  logic      stg_valid [MAX_DIGITS+1];
  logic      stg_ready [MAX_DIGITS+1];
  drr_item_t stg_item  [MAX_DIGITS+1];

  // sign and magnitude split
  drr_abs_stage u_abs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .value_i (value_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .item_o  (stg_item[0])
  );

  // one stage per decimal digit
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
    drr_digit_stage u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .item_i  (stg_item[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .item_o  (stg_item[g+1])
    );
  end

  // sign restore and output register
  drr_sign_stage u_sign (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (stg_valid[MAX_DIGITS]),
    .ready_o       (stg_ready[MAX_DIGITS]),
    .item_i        (stg_item[MAX_DIGITS]),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .reversed_o    (reversed_o),
    .digit_count_o (digit_count_o)
  );

endmodule

/* hw/rtl/drr_abs_stage.sv */
// module: input stage, splits the word into sign and magnitude
`timescale 1ns / 1ps
module drr_abs_stage
  import drr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output drr_item_t                item_o
);

  logic      valid_q;
  drr_item_t item_d;
  drr_item_t item_q;

  // magnitude in 32-bit unsigned, exact for the most negative value too
  always_comb begin
    item_d.neg = value_i[ValueW-1];
    item_d.mag = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
    item_d.rev = '0;
    item_d.cnt = '0;
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hw/rtl/drr_digit_stage.sv */
// module: one digit step, peels the lowest digit and appends it to the result
`timescale 1ns / 1ps
module drr_digit_stage
  import drr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  drr_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output drr_item_t item_o
);

  logic                valid_q;
  drr_item_t           item_d;
  drr_item_t           item_q;
  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   rem;
  logic [3:0]          digit;

  // divide by ten through the reciprocal, remainder by shift and subtract
  always_comb begin
    prod  = {{ValueW{1'b0}}, item_i.mag} * {{ValueW{1'b0}}, Recip10};
    quot  = ValueW'(prod >> Recip10Shift);
    rem   = item_i.mag - ((quot << 3) + (quot << 1));
    digit = rem[3:0];
    item_d = item_i;
    // nothing left: the word passes through unchanged
    if (item_i.mag != '0) begin
      item_d.mag = quot;
      item_d.rev = (item_i.rev << 3) + (item_i.rev << 1) + RevW'(digit);
      item_d.cnt = item_i.cnt + CntW'(1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hw/rtl/drr_sign_stage.sv */
// module: output stage, restores the sign and holds the result word
`timescale 1ns / 1ps
module drr_sign_stage
  import drr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  drr_item_t              item_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [RevW-1:0] reversed_o,
  output logic        [CntW-1:0] digit_count_o
);

  logic            valid_q;
  logic [RevW-1:0] rev_d;
  logic [RevW-1:0] rev_q;
  logic [CntW-1:0] cnt_q;

  // two's complement negate for negative inputs
  assign rev_d   = item_i.neg ? (~item_i.rev + RevW'(1)) : item_i.rev;
  assign ready_o = !valid_q || ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output data
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rev_q <= rev_d;
      cnt_q <= item_i.cnt;
    end
  end

  assign valid_o       = valid_q;
  assign reversed_o    = rev_q;
  assign digit_count_o = cnt_q;

endmodule

/* hw/rtl/drr_checker.sv */
// module: port checker for the decimal digit reverser, with its bind
`timescale 1ns / 1ps
module drr_checker
  import drr_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = DefaultMaxDigits
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic signed [ValueW-1:0] value_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [RevW-1:0] reversed_o,
  input logic        [CntW-1:0] digit_count_o
);

  // an input word waiting for the pipeline stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("input word changed while stalled");

  // a result word waiting for the sink stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reversed_o)
      && $stable(digit_count_o))
    else $error("result word changed while stalled");

  // input back-pressure only comes from a full pipeline ending in a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // zero digits means a zero result and the other way round
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_count_o == '0) == (reversed_o == '0)))
    else $error("digit count and result disagree on zero");

  // digit count never exceeds the converter capacity nor ten digits
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(digit_count_o) <= MAX_DIGITS) && (digit_count_o <= CntW'(10)))
    else $error("digit count out of range");

endmodule

bind decimal_digit_reverse drr_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_drr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .value_i       (value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .reversed_o    (reversed_o),
  .digit_count_o (digit_count_o)
);

/* tb/sv/tb_decimal_digit_reverse.sv */
// testbench: self-checking bench for the pipelined decimal digit reverser
`timescale 1ns / 1ps
module tb_decimal_digit_reverse;
  import drr_pkg::*;

  localparam int unsigned Digits      = DefaultMaxDigits;
  localparam int unsigned PipeDepth   = Digits + 2;
  localparam int unsigned RandomWords = 1100;

  // one word queued for the input channel
  typedef struct {
    bit                wait_idle;
    logic [ValueW-1:0] value;
  } in_word_t;

  // one expected output word
  typedef struct packed {
    logic [RevW-1:0] reversed;
    logic [CntW-1:0] digits;
  } rev_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [RevW-1:0]   reversed_o;
  logic        [CntW-1:0]   digit_count_o;

  in_word_t  words_to_send[$];
  rev_word_t reversals_due[$];
  rev_word_t want;

  int mismatches     = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int input_stalls   = 0;
  int idle_waits     = 0;
  int burst_left     = 16;
  int gap_left       = 0;
  int hold_left      = 0;
  int hold_mark      = 300;
  int holds_done     = 0;
  logic [31:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = 2'd0;
  logic [15:0] rx_pat   = 16'hACE1;

  decimal_digit_reverse #(
    .MAX_DIGITS(Digits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reversed_o   (reversed_o),
    .digit_count_o(digit_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // digits of the magnitude reversed, sign put back, count of digits taken
  function automatic rev_word_t expected_reversal(logic [ValueW-1:0] v);
    rev_word_t   res;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] acc;
    logic [63:0] cnt;
    neg = v[ValueW-1];
    mag = {32'b0, (neg ? (~v + 32'd1) : v)};
    acc = '0;
    cnt = '0;
    for (int i = 0; i < Digits && mag != 0; i++) begin
      acc = acc * 64'd10 + mag % 64'd10;
      mag = mag / 64'd10;
      cnt = cnt + 64'd1;
    end
    if (neg) acc = ~acc + 64'd1;
    res.reversed = acc[RevW-1:0];
    res.digits   = cnt[CntW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_word(logic [ValueW-1:0] v, bit wait_idle);
    in_word_t w;
    w.wait_idle = wait_idle;
    w.value     = v;
    words_to_send.push_back(w);
  endtask

  // sender: bursts with random gaps, some words held back until the pipe drains
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        reversals_due.push_back(expected_reversal(value_i));
        words_sent++;
      end
      if (in_valid_i && !in_ready_o) input_stalls++;
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (words_to_send.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (words_to_send[0].wait_idle &&
                     (in_valid_i || reversals_due.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          if (words_to_send[0].wait_idle) idle_waits++;
          in_valid_i <= 1'b1;
          value_i    <= words_to_send[0].value;
          void'(words_to_send.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            case ($urandom_range(0, 7))
              0, 1, 2, 3: gap_left <= 0;
              4, 5:       gap_left <= $urandom_range(1, 3);
              6:          gap_left <= $urandom_range(4, 12);
              default:    gap_left <= $urandom_range(13, 30);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall pattern drawn at random from four modes, plus long holds
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (results_seen >= hold_mark) begin
      hold_left   <= 120;
      hold_mark   <= hold_mark + 450;
      holds_done++;
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      rx_pat   <= {rx_pat[14:0], rx_pat[15] ^ rx_pat[13] ^ rx_pat[12] ^ rx_pat[10]};
      if (rx_cycle[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= rx_pat[0];
        2'd2:    out_ready_i <= rx_pat[0] & rx_pat[3];
        default: out_ready_i <= (rx_cycle[2:0] != 3'd0);
      endcase
    end
  end

  // checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (reversals_due.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing outstanding", results_seen));
      end else begin
        want = reversals_due.pop_front();
        if (reversed_o !== want.reversed)
          report_mismatch($sformatf("word %0d reversed %0d, expected %0d", results_seen,
                                    reversed_o, $signed(want.reversed)));
        if (digit_count_o !== want.digits)
          report_mismatch($sformatf("word %0d digit_count %0d, expected %0d", results_seen,
                                    digit_count_o, want.digits));
      end
    end
  end

  // stimulus and end of run
  initial begin
    int extremes [20];
    longint lo, hi, p, mag;
    int     nd, tz, sel;
    logic [ValueW-1:0] v;

    extremes = '{0, 1, -1, 9, -9, 10, -10, 120, -123, 100, 5, 12,
                 1000000000, -1000000000, 2147483647, -2147483647,
                 1234567890, -1234567890, 1000000001, 999999999};

    // directed: zero, one digit, trailing zeros, ten digits, both signs
    foreach (extremes[i]) queue_word(extremes[i], 1'b0);
    queue_word(32'h8000_0000, 1'b0);
    queue_word(32'h8000_0001, 1'b0);

    // random: mostly values of a chosen length, some raw bit patterns
    for (int k = 0; k < RandomWords; k++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        v = $urandom;
      end else if (sel == 1) begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = 32'h8000_0000;
          2:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end else begin
        nd = $urandom_range(1, Digits);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = $urandom_range(32'(hi), 32'(lo));
        // knock out low digits so leading zeros vanish on reversal
        if ($urandom_range(0, 3) == 0) begin
          tz = $urandom_range(0, nd - 1);
          p  = 1;
          repeat (tz) p = p * 10;
          mag = mag - mag % p;
        end
        v = mag[ValueW-1:0];
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      queue_word(v, (k == 0 || k == 600));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_to_send.size() != 0 || in_valid_i || reversals_due.size() != 0)
      @(posedge clk_i);
    repeat (3 * PipeDepth) @(posedge clk_i);

    $display("run: %0d words in, %0d results out, incl. zero, most negative value, ten digits",
             words_sent, results_seen);
    $display("run: %0d long receiver holds, %0d input stall cycles, %0d drain pauses",
             holds_done, input_stalls, idle_waits);
    if (mismatches == 0) begin
      $display("** decimal_digit_reverse: PASSED **");
    end else begin
      $display("** decimal_digit_reverse: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout after %0d words in, %0d results out", words_sent, results_seen);
    $display("** decimal_digit_reverse: FAILED **");
    $finish;
  end

endmodule
